[design/feti_pkg.sv]
// Shared types, constants and helper functions for the escape-time pixel unit.
// No dependencies; every design file imports this package.
package feti_pkg;

  // Fixed-point format and frame size
  localparam int FRAC_BITS = 28;
  localparam int MAX_DIM   = 4096;

  // Field widths
  localparam int COORD_W = 12;
  localparam int WORD_W  = 32;
  localparam int STEP_W  = 31;
  localparam int LIMIT_W = 16;
  localparam int KIND_W  = 2;
  localparam int IDX_W   = 3;
  localparam int PAL_W   = 9;
  localparam int PAL_BITS = 8;
  localparam int WIDE_W  = 67;

  // Fractal kinds
  localparam logic [KIND_W-1:0] KIND_MANDEL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_JULIA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BURN   = 2'd2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_KIND   = 3'd0;
  localparam logic [IDX_W-1:0] REG_LIMIT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_XORG   = 3'd2;
  localparam logic [IDX_W-1:0] REG_YORG   = 3'd3;
  localparam logic [IDX_W-1:0] REG_XSTEP  = 3'd4;
  localparam logic [IDX_W-1:0] REG_YSTEP  = 3'd5;

  // Reset values
  localparam logic [LIMIT_W-1:0]       RST_LIMIT = 16'd100;
  localparam logic signed [WORD_W-1:0] RST_XORG  = -32'sd536870912;
  localparam logic signed [WORD_W-1:0] RST_YORG  = -32'sd536870912;
  localparam logic [STEP_W-1:0]        RST_XSTEP = 31'd1677722;
  localparam logic [STEP_W-1:0]        RST_YSTEP = 31'd2236962;

  // Imaginary scale: y / 1.777777 == (y * 1000000 + 888888) / 1777777
  localparam int SCALE_NUM  = 1000000;
  localparam int SCALE_DEN  = 1777777;
  localparam int SCALE_HALF = 888888;
  localparam int DEN_W      = 21;   // bits of the divisor
  localparam int NUM_W      = 51;   // bits of the scaled magnitude
  localparam int QUO_W      = 31;   // quotient stays below 2^31

  // Reciprocal of the divisor in 32 fraction bits; the estimate it gives is
  // the quotient or one less
  localparam int     RECIP_SH    = 32;
  localparam longint SCALE_RECIP = (longint'(1) << RECIP_SH) * SCALE_NUM / SCALE_DEN;
  localparam longint SCALE_RHALF = (longint'(1) << RECIP_SH) * SCALE_HALF / SCALE_DEN;

  // Saturation bounds
  localparam logic signed [WIDE_W-1:0] SAT_MAX = 67'sd2147483647;
  localparam logic signed [WIDE_W-1:0] SAT_MIN = -67'sd2147483648;

  // Work queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > SAT_MAX) begin
      r = SAT_MAX[WORD_W-1:0];
    end else if (v < SAT_MIN) begin
      r = SAT_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // round(p / 2^s), ties toward plus infinity, saturated to a word
  function automatic logic signed [WORD_W-1:0] round_sat(input logic signed [65:0] p,
                                                         input int s);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(p) + (67'sd1 <<< (s - 1));
    t = t >>> s;
    return sat32(t);
  endfunction

  // Derived fixed-point constants
  localparam longint ONE    = longint'(1) << FRAC_BITS;
  localparam longint FOUR   = ONE * 4;
  localparam longint JRE_L  = -((7 * ONE + 5) / 10);
  localparam longint JIM_L  = (27 * ONE + 50) / 100;
  localparam logic signed [WORD_W-1:0] JULIA_RE = sat32(WIDE_W'(JRE_L));
  localparam logic signed [WORD_W-1:0] JULIA_IM = sat32(WIDE_W'(JIM_L));
  localparam logic signed [WIDE_W-1:0] ESC_BOUND = WIDE_W'(FOUR);

  // Configuration bundle
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [LIMIT_W-1:0]       limit;
    logic signed [WORD_W-1:0] x_origin;
    logic signed [WORD_W-1:0] y_origin;
    logic [STEP_W-1:0]        x_step;
    logic [STEP_W-1:0]        y_step;
  } feti_cfg_t;

  // One prepared point: start value and additive constant
  typedef struct packed {
    logic signed [WORD_W-1:0] zx;
    logic signed [WORD_W-1:0] zy;
    logic signed [WORD_W-1:0] cre;
    logic signed [WORD_W-1:0] cim;
  } feti_point_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic not_empty;
  } feti_qstat_t;

endpackage

[design/feti_front.sv]
// Front end: accepts a pixel, maps it to a complex point and, outside Julia mode, scales the
// imaginary part by a reciprocal multiply and one correction. Depends on feti_pkg.
module feti_front import feti_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  feti_cfg_t            cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COORD_W-1:0]   column,
  input  logic [COORD_W-1:0]   row,
  input  feti_qstat_t          qstat,
  output logic                 push,
  output feti_point_t          push_data
);

  localparam logic [2:0] F_IDLE  = 3'd0;
  localparam logic [2:0] F_MUL   = 3'd1;
  localparam logic [2:0] F_SUM   = 3'd2;
  localparam logic [2:0] F_SCALE = 3'd3;
  localparam logic [2:0] F_EST   = 3'd4;
  localparam logic [2:0] F_PUSH  = 3'd5;

  logic [2:0]                 state;
  logic [COORD_W-1:0]         col_r;
  logic [COORD_W-1:0]         row_r;
  logic [COORD_W+STEP_W-1:0]  prod_x;
  logic [COORD_W+STEP_W-1:0]  prod_y;
  logic signed [WORD_W-1:0]   px;
  logic signed [WORD_W-1:0]   py;
  logic                       py_neg;
  logic [NUM_W-1:0]           num;
  logic [QUO_W-1:0]           est;
  logic [DEN_W:0]             rem;

  logic [COORD_W-1:0]         col_clamp;
  logic [COORD_W-1:0]         row_clamp;
  logic signed [WIDE_W-1:0]   sum_x;
  logic signed [WIDE_W-1:0]   sum_y;
  logic [WORD_W:0]            py_negated;
  logic [WORD_W-1:0]          mag;
  logic [NUM_W:0]             num_full;
  logic [2*WORD_W-1:0]        est_full;
  logic [NUM_W-1:0]           back_prod;
  logic [NUM_W-1:0]           diff;
  logic                       ge;
  logic [QUO_W-1:0]           quo;
  logic signed [WORD_W-1:0]   cim_scaled;

  assign in_stall = (state != F_IDLE);

  // Out-of-frame indexes pin to the last pixel
  always_comb begin
    col_clamp = column;
    row_clamp = row;
    if (32'(column) >= MAX_DIM) col_clamp = COORD_W'(MAX_DIM - 1);
    if (32'(row) >= MAX_DIM) row_clamp = COORD_W'(MAX_DIM - 1);
  end

  // Point = origin + index * step, saturated
  assign sum_x = WIDE_W'(cfg.x_origin) + $signed(WIDE_W'(prod_x));
  assign sum_y = WIDE_W'(cfg.y_origin) + $signed(WIDE_W'(prod_y));

  // Magnitude of py times the scale numerator, plus half the divisor
  assign py_negated = -{py[WORD_W-1], py};
  assign mag        = py[WORD_W-1] ? py_negated[WORD_W-1:0] : py;
  assign num_full   = (NUM_W+1)'(mag) * (NUM_W+1)'(SCALE_NUM) + (NUM_W+1)'(SCALE_HALF);

  // Quotient estimate from the reciprocal, never above the true quotient
  assign est_full = (2*WORD_W)'(mag) * (2*WORD_W)'(SCALE_RECIP) +
                    (2*WORD_W)'(SCALE_RHALF);

  // Remainder of the estimate; one divisor or more left means one short
  assign back_prod = NUM_W'(est) * NUM_W'(SCALE_DEN);
  assign diff      = num - back_prod;
  assign ge        = (rem >= (DEN_W+1)'(SCALE_DEN));
  assign quo       = est + QUO_W'(ge);

  assign cim_scaled = py_neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  // Queue entry
  always_comb begin
    if (cfg.kind == KIND_JULIA) begin
      push_data.zx  = px;
      push_data.zy  = py;
      push_data.cre = JULIA_RE;
      push_data.cim = JULIA_IM;
    end else begin
      push_data.zx  = '0;
      push_data.zy  = '0;
      push_data.cre = px;
      push_data.cim = cim_scaled;
    end
  end

  assign push = (state == F_PUSH) && !qstat.full;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE:  if (in_valid) state <= F_MUL;
        F_MUL:   state <= F_SUM;
        F_SUM:   state <= (cfg.kind == KIND_JULIA) ? F_PUSH : F_SCALE;
        F_SCALE: state <= F_EST;
        F_EST:   state <= F_PUSH;
        F_PUSH:  if (!qstat.full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (in_valid) begin
          col_r <= col_clamp;
          row_r <= row_clamp;
        end
      end
      F_MUL: begin
        prod_x <= col_r * cfg.x_step;
        prod_y <= row_r * cfg.y_step;
      end
      F_SUM: begin
        px <= sat32(sum_x);
        py <= sat32(sum_y);
      end
      F_SCALE: begin
        py_neg <= py[WORD_W-1];
        num    <= num_full[NUM_W-1:0];
        est    <= est_full[RECIP_SH +: QUO_W];
      end
      F_EST: begin
        rem <= diff[DEN_W:0];
      end
      default: begin
      end
    endcase
  end

endmodule

[design/feti_queue.sv]
// Short work queue of prepared points between front and back ends.
// Depends on feti_pkg.
module feti_queue import feti_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  feti_point_t push_data,
  input  logic        pop,
  output feti_point_t head,
  output feti_qstat_t qstat
);

  feti_point_t        ents [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign head            = ents[rd_ptr];
  assign qstat.full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign qstat.not_empty = (count != '0);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) ents[wr_ptr] <= push_data;
  end

endmodule

[design/feti_back.sv]
// Back end: escape-time iteration, palette division and output register.
// Depends on feti_pkg.
module feti_back import feti_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  feti_cfg_t           cfg,
  input  feti_qstat_t         qstat,
  input  feti_point_t         head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PAL_W-1:0]    palette_index,
  output logic                inside_set,
  output logic [LIMIT_W-1:0]  iteration_count
);

  localparam logic [2:0] B_IDLE = 3'd0;
  localparam logic [2:0] B_MUL  = 3'd1;
  localparam logic [2:0] B_UPD  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_DONE = 3'd4;

  localparam int PCNT_W = $clog2(PAL_BITS);

  logic [2:0]                state;
  logic signed [WORD_W-1:0]  zx;
  logic signed [WORD_W-1:0]  zy;
  logic signed [WORD_W-1:0]  cre;
  logic signed [WORD_W-1:0]  cim;
  logic signed [65:0]        pxx;
  logic signed [65:0]        pyy;
  logic signed [65:0]        pxy;
  logic [LIMIT_W-1:0]        iter;
  logic [LIMIT_W-1:0]        rem;
  logic [PAL_BITS-1:0]       quo;
  logic [PCNT_W-1:0]         pcnt;
  logic                      res_inside;

  logic signed [WORD_W:0]    ax;
  logic signed [WORD_W:0]    ay;
  logic signed [WORD_W-1:0]  x2;
  logic signed [WORD_W-1:0]  y2;
  logic signed [WORD_W-1:0]  xy;
  logic                      escaped;
  logic [LIMIT_W-1:0]        iter_inc;
  logic [LIMIT_W:0]          ptrial;
  logic                      pge;
  logic                      load_out;

  // Operands: burning ship folds both parts to their magnitudes
  always_comb begin
    ax = (WORD_W+1)'(zx);
    ay = (WORD_W+1)'(zy);
    if (cfg.kind == KIND_BURN) begin
      if (zx < 0) ax = -ax;
      if (zy < 0) ay = -ay;
    end
  end

  // Rounded, saturated products and escape test
  assign x2       = round_sat(pxx, FRAC_BITS);
  assign y2       = round_sat(pyy, FRAC_BITS);
  assign xy       = round_sat(pxy, FRAC_BITS - 1);
  assign escaped  = (WIDE_W'(x2) + WIDE_W'(y2)) > ESC_BOUND;
  assign iter_inc = iter + 1'b1;

  // Palette division step: (iter * 256) / limit
  assign ptrial = {rem, 1'b0};
  assign pge    = (ptrial >= (LIMIT_W+1)'(cfg.limit));

  assign pop      = (state == B_IDLE) && qstat.not_empty;
  assign load_out = (state == B_DONE) && (!out_valid || !out_stall);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        B_IDLE: begin
          if (qstat.not_empty) state <= (cfg.limit == '0) ? B_DONE : B_MUL;
        end
        B_MUL: state <= B_UPD;
        B_UPD: begin
          if (escaped) begin
            state <= B_DIV;
          end else if (iter_inc == cfg.limit) begin
            state <= B_DONE;
          end else begin
            state <= B_MUL;
          end
        end
        B_DIV:  if (pcnt == PCNT_W'(PAL_BITS - 1)) state <= B_DONE;
        B_DONE: if (load_out) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        zx         <= head.zx;
        zy         <= head.zy;
        cre        <= head.cre;
        cim        <= head.cim;
        iter       <= '0;
        res_inside <= 1'b1;
      end
      B_MUL: begin
        pxx <= 66'(zx * zx);
        pyy <= 66'(zy * zy);
        pxy <= ax * ay;
      end
      B_UPD: begin
        if (escaped) begin
          res_inside <= 1'b0;
          rem        <= iter;
          quo        <= '0;
          pcnt       <= '0;
        end else begin
          zx   <= sat32(WIDE_W'(x2) - WIDE_W'(y2) + WIDE_W'(cre));
          zy   <= sat32(WIDE_W'(xy) + WIDE_W'(cim));
          iter <= iter_inc;
        end
      end
      B_DIV: begin
        rem  <= pge ? LIMIT_W'(ptrial - (LIMIT_W+1)'(cfg.limit)) : LIMIT_W'(ptrial);
        quo  <= {quo[PAL_BITS-2:0], pge};
        pcnt <= pcnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      inside_set      <= res_inside;
      palette_index   <= res_inside ? PAL_W'(1 << PAL_BITS) : PAL_W'(quo);
      iteration_count <= iter;
    end
  end

endmodule

[design/fractal_escape_time_pixel_unit.sv]
// Top level of the escape-time pixel unit: configuration registers and the
// front end, work queue and back end. Depends on feti_pkg and feti_* modules.
//
//   channel   handshake               payload
//   input     in_valid / in_stall     column, row
//   output    out_valid / out_stall   palette_index, inside_set, iteration_count
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Front end steps: accept, point multiply, point add, scale multiplies,
// remainder check, queue push; Julia skips the scale multiplies and the
// remainder check. The front end takes a new pixel only after its queue push.
// Back end: pop, then per escape test a multiplier step and a step to round,
// test and update, 8 palette-divider steps when the point escapes, and an
// output register load. The two-entry queue overlaps the two ends. Reset is
// synchronous; cfg_ready is always high. A stalled output holds its item.
module fractal_escape_time_pixel_unit import feti_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [COORD_W-1:0]  column,
  input  logic [COORD_W-1:0]  row,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PAL_W-1:0]    palette_index,
  output logic                inside_set,
  output logic [LIMIT_W-1:0]  iteration_count,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [WORD_W-1:0]   cfg_data
);

  feti_cfg_t    cfg;
  feti_qstat_t  qstat;
  feti_point_t  push_data;
  feti_point_t  head;
  logic         push;
  logic         pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kind     <= KIND_MANDEL;
      cfg.limit    <= RST_LIMIT;
      cfg.x_origin <= RST_XORG;
      cfg.y_origin <= RST_YORG;
      cfg.x_step   <= RST_XSTEP;
      cfg.y_step   <= RST_YSTEP;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KIND:  cfg.kind     <= cfg_data[KIND_W-1:0];
        REG_LIMIT: cfg.limit    <= cfg_data[LIMIT_W-1:0];
        REG_XORG:  cfg.x_origin <= $signed(cfg_data);
        REG_YORG:  cfg.y_origin <= $signed(cfg_data);
        REG_XSTEP: cfg.x_step   <= cfg_data[STEP_W-1:0];
        REG_YSTEP: cfg.y_step   <= cfg_data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  feti_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .column    (column),
    .row       (row),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  feti_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  feti_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .qstat           (qstat),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .palette_index   (palette_index),
    .inside_set      (inside_set),
    .iteration_count (iteration_count)
  );

endmodule
